>>> rtl/core/skis_pkg.sv
// Package for the sorted key/index store: entry and cell control types,
// controller states and the IEEE single compare. No dependencies.
`default_nettype none
package skis_pkg;

   localparam int DEF_CAPACITY = 32;
   localparam int MAX_OUT      = 32;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DEL_MIN  = 2'd1,
      CMD_DEL_MAX  = 2'd2,
      CMD_READOUT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2
   } cell_mode_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] tag;
   } entry_type;

   typedef struct packed {
      cell_mode_type mode;
      entry_type     ins;
   } cell_ctl_type;

   // a < b on IEEE single values; NaN compares false, -0 equals +0
   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan, b_nan, zeros;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (a_nan || b_nan || zeros) begin
         return 1'b0;
      end else if (a[31] != b[31]) begin
         return a[31];
      end else if (!a[31]) begin
         return a[30:0] < b[30:0];
      end else begin
         return a[30:0] > b[30:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/skis_cell.sv
// One slot of the sorted chain: holds an entry, on insert takes the new
// entry or its left neighbor, on rotate its right one. Depends on skis_pkg.
`default_nettype none
module skis_cell (
   input  wire logic                  clock,
   input  skis_pkg::cell_ctl_type     ctl,
   input  wire logic                  occupied,
   input  wire logic                  at_held,
   input  wire logic                  found_in,
   output logic                       found_out,
   input  skis_pkg::entry_type        left_entry,
   input  skis_pkg::entry_type        right_entry,
   output skis_pkg::entry_type        entry
);
   import skis_pkg::*;

   entry_type entry_ff, entry_in;
   logic      hit;

   // an empty slot at the fill point catches a key that beats no entry
   assign hit       = occupied ? flt_lt(ctl.ins.key, entry_ff.key) : at_held;
   assign found_out = found_in | hit;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CELL_INSERT: begin
            if (found_in) begin
               entry_in = left_entry;
            end else if (hit) begin
               entry_in = ctl.ins;
            end
         end
         CELL_ROTATE: entry_in = right_entry;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule
`default_nettype wire

>>> rtl/core/sorted_key_index_store_top.sv
// Top level of the sorted key/index store: controller, result register and
// a chain of skis_cell slots. Depends on skis_pkg and skis_cell.
//
//  channel | dir | tdata (low bit up)            | tuser | tlast
//  req     | in  | key, tag, limit               | cmd   | -
//  rsp     | out | count, out_key, out_tag, status | -   | last
//
// Insert, delete least and delete greatest each give one transaction; the
// next request is taken as soon as the result register is free. Readout
// rotates the whole chain once around, emitting the first min(limit, held,
// 32) slots, so the store is back in order at the end. A stalled result
// holds the rotation.
// Reset clears the fill count, controller and result valid; slot contents
// stay undefined and are never read beyond the fill count.
`default_nettype none
module sorted_key_index_store_top #(
   parameter int CAPACITY = skis_pkg::DEF_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // key[31:0], tag[63:32], limit[69:64]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // count[5:0], out_key[37:6], out_tag[69:38],
                                         // status[71:70]
   output logic             rsp_tlast
);
   import skis_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = $clog2(CAPACITY);

   state_type      state_ff, state_in;
   logic [CW-1:0]  held_ff, held_in;
   logic [KW-1:0]  step_ff, step_in;
   logic [6:0]     num_ff, num_in;
   logic           rvalid_ff, rvalid_in;
   logic [71:0]    rdata_ff, rdata_in;
   logic           rlast_ff, rlast_in;

   cell_ctl_type   ctl;
   entry_type      entries [CAPACITY];
   logic           found [CAPACITY+1];

   logic           slot_free, accept;
   cmd_type        cmd;
   entry_type      req_entry;
   logic [5:0]     limit;
   logic [6:0]     num_calc;
   logic           emit;

   assign cmd       = cmd_type'(req_tuser);
   assign req_entry = '{key: req_tdata[31:0], tag: req_tdata[63:32]};
   assign limit     = req_tdata[69:64];
   assign slot_free = !rvalid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      num_calc = {1'b0, limit};
      if (7'(held_ff) < num_calc) num_calc = 7'(held_ff);
      if (7'(MAX_OUT) < num_calc) num_calc = 7'(MAX_OUT);
   end

   assign emit = 7'(step_ff) < num_ff;

   // controller: next state, chain command and result register
   always_comb begin
      state_in   = state_ff;
      held_in    = held_ff;
      step_in    = step_ff;
      num_in     = num_ff;
      rvalid_in  = rvalid_ff && !rsp_tready;
      rdata_in   = rdata_ff;
      rlast_in   = rlast_ff;
      ctl.mode   = CELL_HOLD;
      ctl.ins    = req_entry;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = slot_free;
            if (accept) begin
               rvalid_in = 1'b1;
               rlast_in  = 1'b1;
               case (cmd)
                  CMD_INSERT: begin
                     if (held_ff >= CW'(CAPACITY)) begin
                        rdata_in = {ST_FULL, 64'd0, 6'(held_ff)};
                     end else begin
                        ctl.mode = CELL_INSERT;
                        held_in  = held_ff + 1'b1;
                        rdata_in = {ST_OK, 64'd0, 6'(held_in)};
                     end
                  end
                  CMD_DEL_MIN, CMD_DEL_MAX: begin
                     if (held_ff == '0) begin
                        rdata_in = {ST_EMPTY, 64'd0, 6'(held_ff)};
                     end else begin
                        if (cmd == CMD_DEL_MIN) ctl.mode = CELL_ROTATE;
                        held_in  = held_ff - 1'b1;
                        rdata_in = {ST_OK, 64'd0, 6'(held_in)};
                     end
                  end
                  default: begin
                     if (num_calc == '0) begin
                        rdata_in = {ST_EMPTY, 64'd0, 6'(held_ff)};
                     end else begin
                        rvalid_in = rvalid_ff && !rsp_tready;
                        num_in    = num_calc;
                        step_in   = '0;
                        state_in  = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            if (!emit || slot_free) begin
               ctl.mode = CELL_ROTATE;
               step_in  = step_ff + 1'b1;
               if (emit) begin
                  rvalid_in = 1'b1;
                  rlast_in  = (7'(step_ff) + 7'd1) == num_ff;
                  rdata_in  = {ST_OK, entries[0].tag, entries[0].key, 6'(held_ff)};
               end
               if (step_ff == KW'(CAPACITY - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         held_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      num_ff   <= num_in;
      rdata_ff <= rdata_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

   // the chain; the last slot takes slot zero on rotate
   assign found[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      skis_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (CW'(i) < held_ff),
         .at_held     (CW'(i) == held_ff),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .left_entry  (entries[(i == 0) ? 0 : i - 1]),
         .right_entry (entries[(i + 1) % CAPACITY]),
         .entry       (entries[i])
      );
   end

   // fill count never passes capacity
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // readout leaves the fill count alone
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> held_ff == $past(held_ff))
      else $error("fill count moved during readout");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp_tready) |=> rvalid_ff && $stable(rdata_ff))
      else $error("result changed while stalled");

endmodule
`default_nettype wire
